@@ rtl/asm_pkg.sv @@
// Package: types, constants and ROM for the alarm state manager.
`default_nettype none
package asm_pkg;
    localparam int NUM_ALARMS  = 20;
    localparam int QUEUE_DEPTH = 32;
    localparam int ROM_ENTRIES = 20;
    localparam int AW = 5;
    localparam int QW = 5;
    localparam int CW = 6;
    localparam int TW = 21;
    localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};
    localparam int SEC_MS = 1000;
    localparam int MIN_MS = 60000;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0, PH_PENDING = 3'd1, PH_ACT_UNACK = 3'd2,
        PH_ACT_ACK = 3'd3, PH_CLR_UNACK = 3'd4, PH_LATCHED = 3'd5
    } t_phase;

    localparam logic [1:0] SEV_INFO = 2'd1;
    localparam logic [1:0] SEV_WARN = 2'd2;
    localparam logic [1:0] SEV_CRIT = 2'd3;

    localparam logic [2:0] F_SET = 3'd0, F_TICK = 3'd1, F_ACK1 = 3'd2,
                           F_ACKALL = 3'd3, F_RESET = 3'd4, F_POP = 3'd5;

    typedef struct packed {
        logic [1:0]    sev;
        logic          latch;
        logic [TW-1:0] on_ms;
        logic [TW-1:0] off_ms;
    } t_rom;

    // Per-alarm record held in the state memory.
    typedef struct packed {
        logic          cond;
        logic [1:0]    csev;
        logic [2:0]    phase;
        logic [1:0]    asev;
        logic [15:0]   occ;
        logic          rgrant;
        logic          supp;
        logic [TW-1:0] on_t;
        logic [TW-1:0] off_t;
    } t_rec;

    typedef struct packed {
        logic [AW-1:0] alarm;
        logic [2:0]    from;
        logic [2:0]    to;
        logic [1:0]    sev;
        logic [15:0]   occ;
        logic          supp;
    } t_event;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  alarm_id;
        logic        cond_active;
        logic [1:0]  cond_severity;
        logic [15:0] dt_ms;
        logic        svc_mode;
    } t_in;

    typedef struct packed {
        logic        done_ok;
        logic [4:0]  ack_count;
        logic [4:0]  ev_alarm;
        logic [2:0]  ev_from;
        logic [2:0]  ev_to;
        logic [1:0]  ev_severity;
        logic [15:0] ev_occurrences;
        logic        ev_suppressed;
        logic        any_alarm;
        logic [1:0]  highest_severity;
        logic [4:0]  act_total;
        logic [4:0]  unack_total;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_WALK, S_SUM, S_OUT
    } t_state;

    function automatic t_rom rom_of(input logic [AW-1:0] a);
        t_rom r;
        r = '{SEV_CRIT, 1'b0, '0, '0};
        unique case (a)
            5'd2:  r = '{SEV_CRIT, 1'b1, '0, TW'(60*SEC_MS)};
            5'd3, 5'd4, 5'd7, 5'd12, 5'd13: r = '{SEV_CRIT, 1'b1, '0, '0};
            5'd5, 5'd6: r = '{SEV_WARN, 1'b0, '0, TW'(10*MIN_MS)};
            5'd8, 5'd9: r = '{SEV_WARN, 1'b0, TW'(60*SEC_MS), '0};
            5'd11, 5'd19: r = '{SEV_WARN, 1'b0, '0, '0};
            5'd15, 5'd17, 5'd18: r = '{SEV_INFO, 1'b0, '0, '0};
            5'd16: r = '{SEV_INFO, 1'b0, TW'(30*MIN_MS), '0};
            default: r = '{SEV_CRIT, 1'b0, '0, '0};
        endcase
        return r;
    endfunction

    function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t, input logic [15:0] d);
        logic [TW:0] s;
        s = {1'b0, t} + {{(TW-15){1'b0}}, d};
        return s[TW] ? TIMER_MAX : s[TW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/asm_if.sv @@
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface asm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/alarm_state_manager.sv @@
// Top level: alarm lifecycle manager with a record memory and an event ring.
//
//  channel  | dir | payload | accepted when
//  i_req    | in  | t_in    | i_req.valid && i_req.ready
//  o_res    | out | t_out   | o_res.valid && o_res.ready
//
// Set, ack one, reset one, pop and unknown functions pass through the read
// and walk states once (only set, ack one and reset one write a record back),
// then a summary pass over all NUM_ALARMS records and an output state. Tick
// and ack all repeat the read and walk states for every record. The record
// memory has one read port and one write port.
// Reset clears records by a valid bit per alarm; the ring needs none.
// A held result stalls only the output cycle; the next transaction is taken
// and processed meanwhile and waits there until the held one leaves.
`default_nettype none
module alarm_state_manager (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    asm_if.sink       i_req,
    asm_if.source     o_res
);
    import asm_pkg::*;

    t_rec   r_mem [NUM_ALARMS];           // alarm records
    t_event r_ring [QUEUE_DEPTH];         // event ring
    logic [NUM_ALARMS-1:0] r_vld;         // record written since reset
    t_rec   r_rd;                         // registered read data
    logic   r_rd_vld;
    t_event r_rq;                         // registered ring read

    t_state r_st, n_st;
    t_in    r_in;
    logic [AW-1:0] r_idx;
    logic [QW-1:0] r_head;
    logic [CW-1:0] r_cnt;
    logic [4:0]    r_acks;
    logic          r_done;
    logic          r_any;
    logic [1:0]    r_hi;
    logic [4:0]    r_act, r_unack;
    t_event        r_ev;                  // popped event, zero when none
    logic          r_ovalid;
    t_out          r_out;
    logic          r_rd_vld_sum;          // summary pass has read data

    localparam logic [AW-1:0] LAST = AW'(NUM_ALARMS-1);

    // Memory read address and write back
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    t_rec          wr_rec;
    logic          ev_en;
    t_event        ev;
    logic          ring_we;
    logic [QW-1:0] ring_waddr;

    t_rec cur;
    assign cur = r_rd_vld ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_idx] <= wr_rec;
        end
        if (ring_we) begin
            r_ring[ring_waddr] <= ev;
        end
        r_rq <= r_ring[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            if (rd_en) r_rd_vld <= r_vld[rd_addr];
            if (wr_en) r_vld[r_idx] <= 1'b1;
        end
    end

    // Record processing for the current item
    t_rom   rom;
    logic   did;
    always_comb begin
        t_rec  x;
        logic  c;
        logic  mv;
        t_phase to;
        rom    = rom_of(r_idx);
        x      = cur;
        c      = 1'b0;
        mv     = 1'b0;
        to     = t_phase'(cur.phase);
        did    = 1'b0;
        unique case (r_in.func)
            F_SET: begin
                x.cond = r_in.cond_active;
                x.csev = (r_in.cond_severity == 2'd0) ? rom.sev : r_in.cond_severity;
            end
            F_TICK: begin
                x.supp = r_in.svc_mode && cur.cond && (cur.csev < SEV_CRIT);
                c = cur.cond && !x.supp;
                if (c && cur.phase != PH_NORMAL && cur.phase != PH_PENDING
                        && cur.csev > cur.asev)
                    x.asev = cur.csev;
                unique case (cur.phase)
                    PH_NORMAL: if (c) begin
                        mv = 1'b1;
                        to = (rom.on_ms == '0) ? PH_ACT_UNACK : PH_PENDING;
                    end
                    PH_PENDING: if (!c) begin
                        mv = 1'b1; to = PH_NORMAL;
                    end else begin
                        x.on_t = tadd(cur.on_t, r_in.dt_ms);
                        if (x.on_t >= rom.on_ms) begin mv = 1'b1; to = PH_ACT_UNACK; end
                    end
                    PH_ACT_UNACK, PH_ACT_ACK: if (!c) begin
                        x.off_t = tadd(cur.off_t, r_in.dt_ms);
                        if (x.off_t >= rom.off_ms) begin
                            mv = 1'b1;
                            if (cur.phase == PH_ACT_UNACK) to = PH_CLR_UNACK;
                            else to = rom.latch ? PH_LATCHED : PH_NORMAL;
                        end
                    end else x.off_t = '0;
                    PH_CLR_UNACK, PH_LATCHED: if (c) begin mv = 1'b1; to = PH_ACT_UNACK; end
                    default: ;
                endcase
            end
            F_ACK1, F_ACKALL: begin
                if (cur.phase == PH_ACT_UNACK) begin
                    mv = 1'b1; to = PH_ACT_ACK; did = 1'b1;
                end else if (cur.phase == PH_CLR_UNACK) begin
                    mv = 1'b1; did = 1'b1;
                    to = (rom.latch && !cur.rgrant) ? PH_LATCHED : PH_NORMAL;
                end
            end
            F_RESET: begin
                if (!cur.cond) begin
                    unique case (cur.phase)
                        PH_LATCHED, PH_ACT_ACK: begin mv = 1'b1; to = PH_NORMAL; did = 1'b1; end
                        PH_CLR_UNACK: begin x.rgrant = 1'b1; did = 1'b1; end
                        PH_ACT_UNACK: begin mv = 1'b1; to = PH_CLR_UNACK; did = 1'b1; end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (mv && to == t_phase'(x.phase)) mv = 1'b0;
        if (mv && to == PH_ACT_UNACK && x.phase != PH_ACT_ACK) begin
            x.rgrant = 1'b0;
            x.occ    = x.occ + 16'd1;
            x.asev   = x.csev;
        end
        ev = '{r_idx, x.phase, 3'(to), x.asev, x.occ, x.supp};
        if (mv) begin
            x.phase = 3'(to);
            x.on_t  = '0;
            x.off_t = '0;
        end
        if (r_in.func == F_RESET && did && to == PH_CLR_UNACK) x.rgrant = 1'b1;
        ev_en  = mv;
        wr_rec = x;
    end

    // Control
    logic proc;
    logic multi;
    logic id_ok;
    logic out_free;
    assign multi = (r_in.func == F_TICK) || (r_in.func == F_ACKALL);
    assign id_ok = r_in.alarm_id < 5'(NUM_ALARMS);
    assign proc  = (r_st == S_WALK) && (multi || ((r_in.func == F_SET
                    || r_in.func == F_ACK1 || r_in.func == F_RESET) && id_ok));
    assign out_free   = !r_ovalid || o_res.ready;
    assign ring_we    = proc && ev_en;
    assign ring_waddr = QW'(r_head + r_cnt[QW-1:0]);

    assign i_req.ready = (r_st == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_req.valid && i_req.ready) n_st = S_RD;
            S_RD:    n_st = S_WALK;
            S_WALK:  if (!multi || r_idx == LAST) n_st = S_SUM;
                     else n_st = S_RD;
            S_SUM:   if (r_idx == LAST && r_rd_vld_sum) n_st = S_OUT;
            S_OUT:   if (out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Summary pass reads one record ahead of the one being counted
    always_comb begin
        rd_en   = ((r_st == S_RD) && (multi || id_ok))
                  || ((r_st == S_SUM) && !(r_rd_vld_sum && r_idx == LAST));
        rd_addr = ((r_st == S_SUM) && r_rd_vld_sum) ? r_idx + AW'(1) : r_idx;
        wr_en   = proc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_head       <= '0;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_idx        <= '0;
            r_rd_vld_sum <= 1'b0;
            r_in         <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_in   <= i_req.data;
                    r_idx  <= (i_req.data.func == F_TICK || i_req.data.func == F_ACKALL)
                              ? '0 : i_req.data.alarm_id;
                    r_acks <= '0;
                    r_done <= 1'b0;
                    r_ev   <= '0;
                end
                S_RD: ;
                S_WALK: begin
                    if (proc && did) begin
                        r_done <= (r_in.func != F_ACKALL);
                        if (r_in.func == F_ACKALL && r_acks != 5'd31) r_acks <= r_acks + 5'd1;
                    end
                    if (ring_we) begin
                        // full ring: overwrite the oldest entry
                        if (r_cnt == CW'(QUEUE_DEPTH)) r_head <= r_head + QW'(1);
                        else r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_in.func == F_POP && r_cnt != '0) begin
                        r_ev   <= r_rq;
                        r_done <= 1'b1;
                        r_head <= r_head + QW'(1);
                        r_cnt  <= r_cnt - CW'(1);
                    end
                    if (!multi || r_idx == LAST) begin
                        r_idx        <= '0;
                        r_rd_vld_sum <= 1'b0;
                        r_any <= 1'b0; r_hi <= '0; r_act <= '0; r_unack <= '0;
                    end else r_idx <= r_idx + AW'(1);
                end
                S_SUM: begin
                    r_rd_vld_sum <= 1'b1;
                    if (r_rd_vld_sum) begin
                        if (cur.phase >= PH_ACT_UNACK && cur.phase <= PH_LATCHED) begin
                            r_any <= 1'b1;
                            if (cur.asev > r_hi) r_hi <= cur.asev;
                        end
                        if (cur.phase == PH_ACT_UNACK || cur.phase == PH_ACT_ACK
                                || cur.phase == PH_LATCHED) r_act <= r_act + 5'd1;
                        if (cur.phase == PH_ACT_UNACK || cur.phase == PH_CLR_UNACK)
                            r_unack <= r_unack + 5'd1;
                        if (r_idx != LAST) r_idx <= r_idx + AW'(1);
                    end
                end
                S_OUT: if (out_free) begin
                    r_out.done_ok          <= r_done;
                    r_out.ack_count        <= r_acks;
                    r_out.ev_alarm         <= r_ev.alarm;
                    r_out.ev_from          <= r_ev.from;
                    r_out.ev_to            <= r_ev.to;
                    r_out.ev_severity      <= r_ev.sev;
                    r_out.ev_occurrences   <= r_ev.occ;
                    r_out.ev_suppressed    <= r_ev.supp;
                    r_out.any_alarm        <= r_any;
                    r_out.highest_severity <= r_hi;
                    r_out.act_total        <= r_act;
                    r_out.unack_total      <= r_unack;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/asm_checker.sv @@
// Port-level checker for the alarm state manager, bound to the top level.
`default_nettype none
module asm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire logic o_valid,
    input wire logic o_ready,
    input wire logic [4:0] o_act,
    input wire logic [4:0] o_unack,
    input wire logic o_any,
    input wire logic [1:0] o_hi
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid) else $error("result dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> $stable({o_act, o_unack, o_any, o_hi}))
        else $error("held result changed");
    a_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_act != 5'd0 || o_unack != 5'd0) |-> o_any)
        else $error("summary inconsistent");
    a_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_any == (o_hi != 2'd0))) else $error("severity inconsistent");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> !i_ready) else $error("input taken while busy");
endmodule

bind alarm_state_manager asm_checker u_asm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(i_req.valid), .i_ready(i_req.ready),
    .o_valid(o_res.valid), .o_ready(o_res.ready),
    .o_act(o_res.data.act_total), .o_unack(o_res.data.unack_total),
    .o_any(o_res.data.any_alarm), .o_hi(o_res.data.highest_severity)
);
`default_nettype wire

@@ bench/alarm_state_manager_tb.sv @@
// Testbench for alarm_state_manager: predicted lifecycle, event ring and summary checks.
`default_nettype none
module alarm_state_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    asm_if #(.T(t_in))  req_ch ();
    asm_if #(.T(t_out)) res_ch ();

    alarm_state_manager i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predicted alarm state, one copy per alarm, plus the event ring.
    // ---------------------------------------------------------------
    logic           cond_q      [NUM_ALARMS];
    logic [1:0]     csev_q      [NUM_ALARMS];
    t_phase         phase_q     [NUM_ALARMS];
    logic [1:0]     asev_q      [NUM_ALARMS];
    logic [15:0]    occ_q       [NUM_ALARMS];
    logic           rgrant_q    [NUM_ALARMS];
    logic           supp_q      [NUM_ALARMS];
    logic [TW-1:0]  on_q        [NUM_ALARMS];
    logic [TW-1:0]  off_q       [NUM_ALARMS];
    t_event         event_log   [$];

    t_out           expected_results [$];

    int  mismatches;
    int  idle_cycles;
    bit  hold_off;      // long receiver stall, driven by its own process
    bit  rx_gaps_on;    // random receiver gaps enabled
    bit  tx_gaps_on;    // random sender gaps enabled

    // Local copy of the alarm table: severity, latch, on and off delays.
    function automatic void alarm_defaults(input int a, output logic [1:0] sev,
                                           output bit latch, output int on_ms,
                                           output int off_ms);
        sev = SEV_CRIT; latch = 0; on_ms = 0; off_ms = 0;
        case (a)
            2:                  begin latch = 1; off_ms = 60000; end
            3, 4, 7, 12, 13:    latch = 1;
            5, 6:               begin sev = SEV_WARN; off_ms = 600000; end
            8, 9:               begin sev = SEV_WARN; on_ms = 60000; end
            11, 19:             sev = SEV_WARN;
            15, 17, 18:         sev = SEV_INFO;
            16:                 begin sev = SEV_INFO; on_ms = 1800000; end
            default:            ;
        endcase
    endfunction

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t, input logic [15:0] d);
        int s;
        s = int'(t) + int'(d);
        return (s > 32'h1FFFFF) ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    // One phase change: records the event, drops the oldest one when full.
    function automatic void change_phase(input int a, input t_phase to);
        t_event e;
        if (phase_q[a] == to) return;
        if (to == PH_ACT_UNACK && phase_q[a] != PH_ACT_ACK) begin
            rgrant_q[a] = 0;
            occ_q[a]    = occ_q[a] + 16'd1;
            asev_q[a]   = csev_q[a];
        end
        e.alarm = a[4:0];
        e.from  = phase_q[a];
        e.to    = to;
        e.sev   = asev_q[a];
        e.occ   = occ_q[a];
        e.supp  = supp_q[a];
        if (event_log.size() >= QUEUE_DEPTH) void'(event_log.pop_front());
        event_log.push_back(e);
        phase_q[a] = to;
        on_q[a]    = '0;
        off_q[a]   = '0;
    endfunction

    function automatic void advance_time(input logic [15:0] dt, input bit svc);
        logic [1:0] sev;
        bit latch, c;
        int on_ms, off_ms;
        t_phase ph;
        for (int a = 0; a < NUM_ALARMS; a++) begin
            alarm_defaults(a, sev, latch, on_ms, off_ms);
            c  = cond_q[a];
            ph = phase_q[a];
            supp_q[a] = svc && c && (csev_q[a] < SEV_CRIT);
            if (supp_q[a]) c = 0;
            if (c && ph != PH_NORMAL && ph != PH_PENDING && csev_q[a] > asev_q[a])
                asev_q[a] = csev_q[a];
            case (ph)
                PH_NORMAL:
                    if (c) change_phase(a, (on_ms == 0) ? PH_ACT_UNACK : PH_PENDING);
                PH_PENDING:
                    if (!c) change_phase(a, PH_NORMAL);
                    else begin
                        on_q[a] = sat_add(on_q[a], dt);
                        if (int'(on_q[a]) >= on_ms) change_phase(a, PH_ACT_UNACK);
                    end
                PH_ACT_UNACK, PH_ACT_ACK:
                    if (!c) begin
                        off_q[a] = sat_add(off_q[a], dt);
                        if (int'(off_q[a]) >= off_ms) begin
                            if (ph == PH_ACT_UNACK) change_phase(a, PH_CLR_UNACK);
                            else change_phase(a, latch ? PH_LATCHED : PH_NORMAL);
                        end
                    end else off_q[a] = '0;
                PH_CLR_UNACK, PH_LATCHED:
                    if (c) change_phase(a, PH_ACT_UNACK);
                default: ;
            endcase
        end
    endfunction

    function automatic bit acknowledge(input int a);
        logic [1:0] sev;
        bit latch;
        int on_ms, off_ms;
        alarm_defaults(a, sev, latch, on_ms, off_ms);
        if (phase_q[a] == PH_ACT_UNACK) begin
            change_phase(a, PH_ACT_ACK);
            return 1;
        end
        if (phase_q[a] == PH_CLR_UNACK) begin
            change_phase(a, (latch && !rgrant_q[a]) ? PH_LATCHED : PH_NORMAL);
            return 1;
        end
        return 0;
    endfunction

    // Operator reset is refused while the raw condition holds.
    function automatic bit operator_reset(input int a);
        if (cond_q[a]) return 0;
        case (phase_q[a])
            PH_LATCHED, PH_ACT_ACK: begin change_phase(a, PH_NORMAL); return 1; end
            PH_CLR_UNACK: begin rgrant_q[a] = 1; return 1; end
            PH_ACT_UNACK: begin
                change_phase(a, PH_CLR_UNACK);
                rgrant_q[a] = 1;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_out predict_result(input t_in x);
        t_out r;
        logic [1:0] sev;
        bit latch;
        int on_ms, off_ms, acks, act, unack;
        bit id_ok;
        t_event e;
        r = '0;
        acks = 0; act = 0; unack = 0;
        id_ok = x.alarm_id < NUM_ALARMS;
        case (x.func)
            F_SET:
                if (id_ok) begin
                    alarm_defaults(x.alarm_id, sev, latch, on_ms, off_ms);
                    cond_q[x.alarm_id] = x.cond_active;
                    csev_q[x.alarm_id] = (x.cond_severity == 0) ? sev : x.cond_severity;
                end
            F_TICK:   advance_time(x.dt_ms, x.svc_mode);
            F_ACK1:   if (id_ok && acknowledge(x.alarm_id)) r.done_ok = 1;
            F_ACKALL: for (int a = 0; a < NUM_ALARMS; a++) if (acknowledge(a)) acks++;
            F_RESET:  if (id_ok && operator_reset(x.alarm_id)) r.done_ok = 1;
            F_POP:
                if (event_log.size() > 0) begin
                    e = event_log.pop_front();
                    r.done_ok        = 1;
                    r.ev_alarm       = e.alarm;
                    r.ev_from        = e.from;
                    r.ev_to          = e.to;
                    r.ev_severity    = e.sev;
                    r.ev_occurrences = e.occ;
                    r.ev_suppressed  = e.supp;
                end
            default: ;
        endcase
        for (int a = 0; a < NUM_ALARMS; a++) begin
            if (phase_q[a] inside {PH_ACT_UNACK, PH_ACT_ACK, PH_CLR_UNACK, PH_LATCHED}) begin
                r.any_alarm = 1;
                if (asev_q[a] > r.highest_severity) r.highest_severity = asev_q[a];
            end
            if (phase_q[a] inside {PH_ACT_UNACK, PH_ACT_ACK, PH_LATCHED}) act++;
            if (phase_q[a] inside {PH_ACT_UNACK, PH_CLR_UNACK}) unack++;
        end
        r.ack_count   = 5'(acks);
        r.act_total   = 5'(act);
        r.unack_total = 5'(unack);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: offers one transaction, waits for acceptance.
    // Prediction happens at acceptance so order always matches.
    // ---------------------------------------------------------------
    task automatic send_item(input t_in x);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= x;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_results.push_back(predict_result(x));
        req_ch.valid <= 1'b0;
        // the block is busy after an accept
        @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [2:0] f, input int id = 0,
                                      input bit c = 0, input int sv = 0,
                                      input int dt = 0, input bit svc = 0);
        t_in x;
        x.func = f; x.alarm_id = id[4:0]; x.cond_active = c;
        x.cond_severity = sv[1:0]; x.dt_ms = dt[15:0]; x.svc_mode = svc;
        return x;
    endfunction

    // Random field noise in the unused fields keeps every input bit toggling.
    function automatic t_in random_item();
        t_in x;
        int sel;
        x = t_in'($bits(t_in)'($urandom));
        sel = $urandom_range(0, 99);
        if      (sel < 30) x.func = F_SET;
        else if (sel < 55) x.func = F_TICK;
        else if (sel < 65) x.func = F_ACK1;
        else if (sel < 69) x.func = F_ACKALL;
        else if (sel < 77) x.func = F_RESET;
        else if (sel < 97) x.func = F_POP;
        else               x.func = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 15) != 0) x.alarm_id = 5'($urandom_range(0, NUM_ALARMS - 1));
        // Short, medium or full-range ticks; long ones help clear the long delays.
        case ($urandom_range(0, 3))
            0:       x.dt_ms = 16'($urandom_range(0, 100));
            1:       x.dt_ms = 16'($urandom_range(0, 20000));
            default: ;
        endcase
        x.svc_mode = ($urandom_range(0, 4) == 0);
        return x;
    endfunction

    task automatic drain_ring();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) send_item(make_item(F_POP));
    endtask

    // Directed: alarm id extremes, every function, refused reset.
    task automatic test_directed();
        send_item(make_item(F_POP));                         // pop on empty ring
        send_item(make_item(F_SET, 0, 1, 0));
        send_item(make_item(F_SET, 19, 1, 1));
        send_item(make_item(F_SET, 31, 1, 3));               // out of range id
        send_item(make_item(F_SET, 8, 1, 2));
        send_item(make_item(F_TICK, 0, 0, 0, 0, 0));
        send_item(make_item(F_TICK, 0, 0, 0, 65535, 0));
        send_item(make_item(F_RESET, 0));                    // refused, condition holds
        send_item(make_item(F_ACK1, 0));
        send_item(make_item(F_ACK1, 31));
        send_item(make_item(F_SET, 0, 0, 0));
        send_item(make_item(F_RESET, 0));
        send_item(make_item(F_SET, 15, 1, 0));
        send_item(make_item(F_TICK, 0, 0, 0, 10, 1));        // service mode suppresses info
        send_item(make_item(F_ACKALL));
        send_item(make_item(F_RESET, 31));
        send_item(make_item(3'd6));
        send_item(make_item(3'd7, 31, 1, 3, 65535, 1));
        send_item(make_item(F_POP));
        send_item(make_item(F_POP));
    endtask

    // Toggle alarm 1 many times to load the ring with events, then drain it.
    task automatic test_ring_overflow();
        for (int i = 0; i < 24; i++) begin
            send_item(make_item(F_SET, 1, i % 2, 0));
            send_item(make_item(F_TICK, 0, 0, 0, 1, 0));
        end
        drain_ring();
    endtask

    // Long timers: pending and off delays.
    task automatic test_timers();
        send_item(make_item(F_SET, 16, 1, 0));
        send_item(make_item(F_SET, 2, 1, 0));
        send_item(make_item(F_TICK));
        send_item(make_item(F_SET, 2, 0, 0));
        for (int i = 0; i < 40; i++) send_item(make_item(F_TICK, 0, 0, 0, 65535, 0));
        send_item(make_item(F_ACKALL));
        send_item(make_item(F_RESET, 2));
        drain_ring();
    endtask

    // Receiver held off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++) send_item(random_item());
        hold_off = 1'b0;
    endtask

    task automatic test_random(input int n);
        t_in x;
        int id;
        for (int i = 0; i < n; i++) begin
            // Mostly well-formed lifecycles: raise, tick, ack, clear, reset.
            if ($urandom_range(0, 2) == 0) begin
                id = $urandom_range(0, NUM_ALARMS - 1);
                send_item(make_item(F_SET, id, 1, $urandom_range(0, 3)));
                send_item(make_item(F_TICK, 0, 0, 0, $urandom_range(0, 65535),
                                    $urandom_range(0, 1)));
                send_item(make_item(F_ACK1, id));
                send_item(make_item(F_SET, id, 0, 0));
                send_item(make_item(F_TICK, 0, 0, 0, $urandom_range(0, 65535), 0));
                send_item(make_item(F_RESET, id));
                send_item(make_item(F_POP));
                i += 6;
            end else begin
                x = random_item();
                send_item(x);
            end
        end
    endtask

    // Receiver: random ready, long hold-off on request.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                res_ch.ready <= 1'b1;
                wait (!hold_off);
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", res_ch.data);
            end else begin
                want = expected_results.pop_front();
                if (res_ch.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, res_ch.data);
                end
            end
        end
    end

    // Watchdog: cycles in which no transaction is accepted.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("alarm_state_manager_tb: FAIL");
            $finish;
        end
    end

    initial begin
        mismatches   = 0;
        idle_cycles  = 0;
        hold_off     = 0;
        rx_gaps_on   = 0;
        tx_gaps_on   = 0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        for (int a = 0; a < NUM_ALARMS; a++) begin
            cond_q[a] = 0; csev_q[a] = 0; phase_q[a] = PH_NORMAL; asev_q[a] = 0;
            occ_q[a] = 0; rgrant_q[a] = 0; supp_q[a] = 0; on_q[a] = 0; off_q[a] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_ring_overflow();
        test_timers();
        rx_gaps_on = 1;
        tx_gaps_on = 1;
        test_backpressure();
        test_random(600);
        rx_gaps_on = 0;
        tx_gaps_on = 0;
        test_random(300);
        rx_gaps_on = 1;
        tx_gaps_on = 1;
        test_random(250);

        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("alarm_state_manager_tb: PASS");
        else
            $display("alarm_state_manager_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
